>>> rtl/v3a_pkg.sv
// v3a_pkg: shared types, opcodes and helpers for the vector3_alu block
// no dependencies; used by every module of the block except v3a_queue

package v3a_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned EPS_W         = 16;
  localparam int unsigned OP_W          = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned RAD_W         = 2 * DATA_W;

  localparam logic [EPS_W-1:0]    EPS_RESET    = 16'd1;
  localparam logic [2*EPS_W-1:0]  EPS_SQ_RESET = 32'd1;
  localparam logic [DATA_W-1:0]   WORD_MAX     = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0]   WORD_MIN     = 32'h8000_0000;

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD       = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB       = 4'd1;
  localparam logic [OP_W-1:0] OP_NEG       = 4'd2;
  localparam logic [OP_W-1:0] OP_SCALE     = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV       = 4'd4;
  localparam logic [OP_W-1:0] OP_CROSS     = 4'd5;
  localparam logic [OP_W-1:0] OP_DOT       = 4'd6;
  localparam logic [OP_W-1:0] OP_TRIPLE    = 4'd7;
  localparam logic [OP_W-1:0] OP_NORM      = 4'd8;
  localparam logic [OP_W-1:0] OP_NORMALIZE = 4'd9;
  localparam logic [OP_W-1:0] OP_PROJ      = 4'd10;
  localparam logic [OP_W-1:0] OP_EQ        = 4'd11;
  localparam logic [OP_W-1:0] OP_NE        = 4'd12;

  typedef logic [DATA_W-1:0] word_t;

  // classified item as it leaves the front end
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    word_t [2:0]        a;
    word_t [2:0]        c;
    word_t [5:0]        ma;
    word_t [5:0]        mb;
    word_t [2:0]        early;
    logic [2:0][15:0]   m16;
    logic               eq_big;
    word_t              den_mag;
    logic               den_neg;
    logic               err;
  } front_t;

  // partial results carried down the back end
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    word_t [2:0]        a;
    word_t [2:0]        vec;
    word_t              rs;
    logic               tt;
    logic               err;
    word_t              den_mag;
    logic               den_neg;
  } back_t;

  // saturate a wide signed value to 32 bits
  function automatic word_t sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return WORD_MAX;
    end else if (v < -68'sd2147483648) begin
      return WORD_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

>>> rtl/v3a_front.sv
// v3a_front: accepts items, classifies them and selects multiplier and divider operands
// depends on v3a_pkg

module v3a_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [v3a_pkg::OP_W-1:0]     opcode_i,
  input  v3a_pkg::word_t [2:0]         a_i,
  input  v3a_pkg::word_t [2:0]         b_i,
  input  v3a_pkg::word_t [2:0]         c_i,
  input  v3a_pkg::word_t               scalar_i,
  input  logic [v3a_pkg::EPS_W-1:0]    eps_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output v3a_pkg::front_t              out_o
);

  logic                  valid_q;
  v3a_pkg::front_t       f_d, f_q;
  logic signed [32:0]    diff;
  logic [32:0]           diff_mag;
  v3a_pkg::word_t        s_mag, az_mag;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = f_q;

  // classification and operand selection
  always_comb begin
    f_d        = '0;
    f_d.opcode = opcode_i;
    f_d.a      = a_i;
    f_d.c      = c_i;
    s_mag      = scalar_i[v3a_pkg::DATA_W-1] ? (-scalar_i) : scalar_i;
    az_mag     = a_i[2][v3a_pkg::DATA_W-1] ? (-a_i[2]) : a_i[2];
    diff       = '0;
    diff_mag   = '0;
    // component differences for the equality tests
    for (int i = 0; i < 3; i++) begin
      diff     = 33'($signed(a_i[i])) - 33'($signed(b_i[i]));
      diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
      if (diff_mag[32:16] != '0) begin
        f_d.eq_big = 1'b1;
      end
      f_d.m16[i] = diff_mag[15:0];
    end
    unique case (opcode_i)
      v3a_pkg::OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          f_d.early[i] = v3a_pkg::sat32(68'($signed(a_i[i])) + 68'($signed(b_i[i])));
        end
      end
      v3a_pkg::OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          f_d.early[i] = v3a_pkg::sat32(68'($signed(a_i[i])) - 68'($signed(b_i[i])));
        end
      end
      v3a_pkg::OP_NEG: begin
        for (int i = 0; i < 3; i++) begin
          f_d.early[i] = v3a_pkg::sat32(-68'($signed(a_i[i])));
        end
      end
      v3a_pkg::OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          f_d.ma[i] = a_i[i];
          f_d.mb[i] = scalar_i;
        end
      end
      v3a_pkg::OP_CROSS, v3a_pkg::OP_TRIPLE: begin
        f_d.ma[0] = a_i[1]; f_d.mb[0] = b_i[2];
        f_d.ma[1] = a_i[2]; f_d.mb[1] = b_i[1];
        f_d.ma[2] = a_i[2]; f_d.mb[2] = b_i[0];
        f_d.ma[3] = a_i[0]; f_d.mb[3] = b_i[2];
        f_d.ma[4] = a_i[0]; f_d.mb[4] = b_i[1];
        f_d.ma[5] = a_i[1]; f_d.mb[5] = b_i[0];
      end
      v3a_pkg::OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          f_d.ma[i] = a_i[i];
          f_d.mb[i] = b_i[i];
        end
      end
      v3a_pkg::OP_NORM, v3a_pkg::OP_NORMALIZE: begin
        for (int i = 0; i < 3; i++) begin
          f_d.ma[i] = a_i[i];
          f_d.mb[i] = a_i[i];
        end
      end
      v3a_pkg::OP_DIV: begin
        f_d.den_mag = s_mag;
        f_d.den_neg = scalar_i[v3a_pkg::DATA_W-1];
        f_d.err     = (scalar_i == '0) || (s_mag < v3a_pkg::word_t'(eps_i));
      end
      v3a_pkg::OP_PROJ: begin
        f_d.den_mag = az_mag;
        f_d.den_neg = a_i[2][v3a_pkg::DATA_W-1];
        f_d.err     = (az_mag <= v3a_pkg::word_t'(eps_i));
      end
      default: begin
      end
    endcase
  end

  // front register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      f_q <= f_d;
    end
  end

endmodule

>>> rtl/v3a_queue.sv
// v3a_queue: short first-in first-out queue between front and back end
// depends on nothing but its parameters

module v3a_queue #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [W-1:0]  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [W-1:0]  out_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign in_ready_o  = (count_q != CNT_W'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = store_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

>>> rtl/v3a_sqrt.sv
// v3a_sqrt: pipelined integer square root, one result bit per stage
// depends on v3a_pkg

module v3a_sqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  logic [v3a_pkg::RAD_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          out_valid_o,
  output v3a_pkg::word_t                root_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int unsigned RW     = v3a_pkg::RAD_W;
  localparam int unsigned QW     = RW / 2;
  localparam int unsigned STAGES = QW + 1;

  logic [STAGES-1:0] valid_q;
  logic [RW-1:0]     rem_q  [STAGES];
  logic [QW-1:0]     root_q [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[STAGES-2:0], in_valid_i};
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rad_i;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  // one root bit per stage, highest first
  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int unsigned K = QW - 1 - j;
    logic [RW+1:0] trial;
    logic          take;

    assign trial = ((RW+2)'(root_q[j]) << (K + 1)) + ((RW+2)'(1) << (2 * K));
    assign take  = (RW+2)'(rem_q[j]) >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j+1] <= side_q[j];
        if (take) begin
          rem_q[j+1]  <= rem_q[j] - trial[RW-1:0];
          root_q[j+1] <= root_q[j] | (QW'(1) << K);
        end else begin
          rem_q[j+1]  <= rem_q[j];
          root_q[j+1] <= root_q[j];
        end
      end
    end
  end

  assign out_valid_o = valid_q[STAGES-1];
  assign root_o      = root_q[STAGES-1];
  assign side_o      = side_q[STAGES-1];

endmodule

>>> rtl/v3a_div.sv
// v3a_div: pipelined restoring divider for fixed-point quotients, several lanes, one bit a stage
// depends on v3a_pkg

module v3a_div #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF,
  parameter int unsigned SIDE_W    = 1,
  parameter int unsigned LANES     = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          in_valid_i,
  input  v3a_pkg::word_t [LANES-1:0]    num_i,
  input  v3a_pkg::word_t                den_mag_i,
  input  logic                          den_neg_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          out_valid_o,
  output v3a_pkg::word_t [LANES-1:0]    quo_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam int unsigned DW     = v3a_pkg::DATA_W;
  localparam int unsigned NW     = DW + FRAC_BITS;
  localparam int unsigned QW     = DW + 1;
  localparam int unsigned STAGES = QW + 1;

  logic [STAGES-1:0] valid_q;
  logic [NW-1:0]     rem_q  [STAGES][LANES];
  logic [QW-1:0]     quo_q  [STAGES][LANES];
  logic [LANES-1:0]  ovf_q  [STAGES];
  logic [LANES-1:0]  neg_q  [STAGES];
  logic [DW-1:0]     den_q  [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];

  logic [DW-1:0]     nmag [LANES];
  logic [NW-1:0]     nsh  [LANES];
  logic [LANES-1:0]  ovf0, neg0;

  // numerator magnitudes scaled by the fraction, overflow precheck
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      nmag[l] = num_i[l][DW-1] ? (-num_i[l]) : num_i[l];
      nsh[l]  = NW'(nmag[l]) << FRAC_BITS;
      ovf0[l] = (nsh[l] >> QW) >= NW'(den_mag_i);
      neg0[l] = num_i[l][DW-1] ^ den_neg_i;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[STAGES-2:0], in_valid_i};
    end
  end

  // input stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0]  <= den_mag_i;
      side_q[0] <= side_i;
      ovf_q[0]  <= ovf0;
      neg_q[0]  <= neg0;
      for (int l = 0; l < LANES; l++) begin
        rem_q[0][l] <= nsh[l];
        quo_q[0][l] <= '0;
      end
    end
  end

  // one quotient bit per stage, highest first
  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int unsigned K = QW - 1 - j;
    logic [LANES-1:0] take;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        take[l] = (rem_q[j][l] >> K) >= NW'(den_q[j]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j+1]  <= den_q[j];
        side_q[j+1] <= side_q[j];
        ovf_q[j+1]  <= ovf_q[j];
        neg_q[j+1]  <= neg_q[j];
        for (int l = 0; l < LANES; l++) begin
          if (take[l]) begin
            rem_q[j+1][l] <= rem_q[j][l] - (NW'(den_q[j]) << K);
            quo_q[j+1][l] <= quo_q[j][l] | (QW'(1) << K);
          end else begin
            rem_q[j+1][l] <= rem_q[j][l];
            quo_q[j+1][l] <= quo_q[j][l];
          end
        end
      end
    end
  end

  // sign and saturation
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (ovf_q[STAGES-1][l]) begin
        quo_o[l] = neg_q[STAGES-1][l] ? v3a_pkg::WORD_MIN : v3a_pkg::WORD_MAX;
      end else if (!neg_q[STAGES-1][l]) begin
        quo_o[l] = (quo_q[STAGES-1][l] > QW'(v3a_pkg::WORD_MAX)) ?
                   v3a_pkg::WORD_MAX : quo_q[STAGES-1][l][DW-1:0];
      end else begin
        quo_o[l] = (quo_q[STAGES-1][l] > QW'(v3a_pkg::WORD_MIN)) ?
                   v3a_pkg::WORD_MIN : (-quo_q[STAGES-1][l][DW-1:0]);
      end
    end
  end

  assign out_valid_o = valid_q[STAGES-1];
  assign side_o      = side_q[STAGES-1];

endmodule

>>> rtl/vector3_alu.sv
// vector3_alu: three-component vector ALU in signed fixed point, top level
// depends on v3a_pkg, v3a_front, v3a_queue, v3a_sqrt, v3a_div
//
// Usage
//   s_axis carries one operation per transfer: opcode in tuser, vectors a, b, c and
//   the scalar in tdata. m_axis returns one result per input transfer, in order.
//   cfg_valid_i/cfg_data_i write the zero threshold; the port is always ready and
//   should only be written while no operation is in flight.
//   Throughput is one operation per cycle while m_axis_tready stays high. From an
//   input transfer to the result being offered an item passes one front register, one
//   queue slot, three multiply and sum stages, 33 stages of the square-root pipeline
//   (a root bit in each but the input stage) and 34 stages of the divider (a quotient
//   bit in each but the input stage), then the output register. Every operation walks the whole pipeline.
//   When m_axis_tready is low while a result is offered, the back end freezes as a
//   whole; the front register and the two-entry queue keep taking transfers until they
//   fill, then s_axis_tready drops.
//   Reset clears all valid state and sets the threshold to one LSB.

module vector3_alu #(
  parameter int unsigned FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, scalar_in (32 bits each, from bit 0)
  input  logic [319:0]  s_axis_tdata,
  // opcode
  input  logic [3:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // r_x, r_y, r_z, r_scalar (32 bits each), test_true, zero fill (from bit 0)
  output logic [135:0]  m_axis_tdata,
  // error
  output logic [0:0]    m_axis_tuser,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [15:0]   cfg_data_i
);

  localparam int unsigned DW  = v3a_pkg::DATA_W;
  localparam int unsigned FW  = $bits(v3a_pkg::front_t);
  localparam int unsigned BW  = $bits(v3a_pkg::back_t);
  localparam v3a_pkg::word_t ONE_Q = v3a_pkg::word_t'(1) << FRAC_BITS;

  // threshold register
  logic [v3a_pkg::EPS_W-1:0]   eps_q;
  logic [2*v3a_pkg::EPS_W-1:0] eps_sq_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q    <= v3a_pkg::EPS_RESET;
      eps_sq_q <= v3a_pkg::EPS_SQ_RESET;
    end else if (cfg_valid_i) begin
      eps_q    <= cfg_data_i;
      eps_sq_q <= 32'(cfg_data_i) * 32'(cfg_data_i);
    end
  end

  // input unpacking
  v3a_pkg::word_t [2:0] in_a, in_b, in_c;
  v3a_pkg::word_t       in_s;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_a[i] = s_axis_tdata[DW*i +: DW];
      in_b[i] = s_axis_tdata[DW*(i+3) +: DW];
      in_c[i] = s_axis_tdata[DW*(i+6) +: DW];
    end
    in_s = s_axis_tdata[DW*9 +: DW];
  end

  // front end
  logic            fr_valid, fr_ready;
  v3a_pkg::front_t fr_data;

  v3a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .a_i         (in_a),
    .b_i         (in_b),
    .c_i         (in_c),
    .scalar_i    (in_s),
    .eps_i       (eps_q),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_o       (fr_data)
  );

  // queue between front and back
  logic            q_valid, en;
  logic [FW-1:0]   q_raw;
  v3a_pkg::front_t q_data;

  v3a_queue #(
    .W     (FW),
    .DEPTH (v3a_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   (FW'(fr_data)),
    .out_valid_o (q_valid),
    .out_ready_i (en),
    .out_data_o  (q_raw)
  );

  assign q_data = v3a_pkg::front_t'(q_raw);

  // back end advances whenever the output register can move
  logic m_valid_q;
  assign en = !m_valid_q || m_axis_tready;

  // stage 1: products
  logic                b1_valid_q;
  v3a_pkg::front_t     b1_f_q;
  logic signed [63:0]  b1_p_q  [6];
  logic [31:0]         b1_sq_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_f_q <= q_data;
      for (int i = 0; i < 6; i++) begin
        b1_p_q[i] <= $signed(q_data.ma[i]) * $signed(q_data.mb[i]);
      end
      for (int i = 0; i < 3; i++) begin
        b1_sq_q[i] <= 32'(q_data.m16[i]) * 32'(q_data.m16[i]);
      end
    end
  end

  // stage 2: differences and sums of products
  logic signed [65:0]   cr_raw [3];
  logic signed [65:0]   dot_raw;
  v3a_pkg::word_t [2:0] cr_v, sc_v;
  v3a_pkg::word_t       dot_v;
  logic [33:0]          eq_sum;
  logic                 eq_true;
  v3a_pkg::back_t       b2_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr_raw[k] = 66'(b1_p_q[2*k]) - 66'(b1_p_q[2*k+1]);
      cr_v[k]   = v3a_pkg::sat32(68'(cr_raw[k] >>> FRAC_BITS));
      sc_v[k]   = v3a_pkg::sat32(68'(b1_p_q[k] >>> FRAC_BITS));
    end
    dot_raw = 66'(b1_p_q[0]) + 66'(b1_p_q[1]) + 66'(b1_p_q[2]);
    dot_v   = v3a_pkg::sat32(68'(dot_raw >>> FRAC_BITS));
    eq_sum  = 34'(b1_sq_q[0]) + 34'(b1_sq_q[1]) + 34'(b1_sq_q[2]);
    eq_true = !b1_f_q.eq_big && (eq_sum < 34'(eps_sq_q));

    b2_d         = '0;
    b2_d.opcode  = b1_f_q.opcode;
    b2_d.a       = b1_f_q.a;
    b2_d.err     = b1_f_q.err;
    b2_d.den_mag = b1_f_q.den_mag;
    b2_d.den_neg = b1_f_q.den_neg;
    unique case (b1_f_q.opcode)
      v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_NEG: b2_d.vec = b1_f_q.early;
      v3a_pkg::OP_SCALE:                                 b2_d.vec = sc_v;
      v3a_pkg::OP_CROSS, v3a_pkg::OP_TRIPLE:             b2_d.vec = cr_v;
      v3a_pkg::OP_DOT:                                   b2_d.rs  = dot_v;
      v3a_pkg::OP_EQ:                                    b2_d.tt  = eq_true;
      v3a_pkg::OP_NE:                                    b2_d.tt  = !eq_true;
      default: begin
      end
    endcase
  end

  logic                 b2_valid_q;
  v3a_pkg::back_t       b2_q;
  v3a_pkg::word_t [2:0] b2_c_q;
  logic [63:0]          b2_nsum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q      <= b2_d;
      b2_c_q    <= b1_f_q.c;
      b2_nsum_q <= dot_raw[63:0];
    end
  end

  // stage 3: triple product multiplies
  logic                b3_valid_q;
  v3a_pkg::back_t      b3_q;
  logic [63:0]         b3_nsum_q;
  logic signed [63:0]  b3_t_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      b3_q      <= b2_q;
      b3_nsum_q <= b2_nsum_q;
      for (int i = 0; i < 3; i++) begin
        b3_t_q[i] <= $signed(b2_q.vec[i]) * $signed(b2_c_q[i]);
      end
    end
  end

  // valid bits of the short stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
    end else if (en) begin
      b1_valid_q <= q_valid;
      b2_valid_q <= b1_valid_q;
      b3_valid_q <= b2_valid_q;
    end
  end

  // triple sum into the square-root pipeline
  logic signed [65:0] tri_raw;
  v3a_pkg::back_t     sq_in;

  always_comb begin
    tri_raw = 66'(b3_t_q[0]) + 66'(b3_t_q[1]) + 66'(b3_t_q[2]);
    sq_in   = b3_q;
    if (b3_q.opcode == v3a_pkg::OP_TRIPLE) begin
      sq_in.rs = v3a_pkg::sat32(68'(tri_raw >>> FRAC_BITS));
    end
  end

  logic            sq_valid;
  v3a_pkg::word_t  sq_root;
  logic [BW-1:0]   sq_side;

  v3a_sqrt #(
    .SIDE_W (BW)
  ) u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (b3_valid_q),
    .rad_i       (b3_nsum_q),
    .side_i      (BW'(sq_in)),
    .out_valid_o (sq_valid),
    .root_o      (sq_root),
    .side_o      (sq_side)
  );

  // norm results and divisor selection
  v3a_pkg::back_t       dv_in;
  v3a_pkg::word_t [2:0] dv_num;

  always_comb begin
    dv_in  = v3a_pkg::back_t'(sq_side);
    dv_num = dv_in.a;
    unique case (dv_in.opcode)
      v3a_pkg::OP_NORM: begin
        dv_in.rs = sq_root[DW-1] ? v3a_pkg::WORD_MAX : sq_root;
      end
      v3a_pkg::OP_NORMALIZE: begin
        dv_in.den_mag = sq_root;
        dv_in.den_neg = 1'b0;
        dv_in.err     = (sq_root == '0) || (sq_root < v3a_pkg::word_t'(eps_q));
      end
      default: begin
      end
    endcase
  end

  logic                 dv_valid;
  v3a_pkg::word_t [2:0] dv_quo;
  logic [BW-1:0]        dv_side;
  v3a_pkg::back_t       fin;

  v3a_div #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (BW),
    .LANES     (3)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (sq_valid),
    .num_i       (dv_num),
    .den_mag_i   (dv_in.den_mag),
    .den_neg_i   (dv_in.den_neg),
    .side_i      (BW'(dv_in)),
    .out_valid_o (dv_valid),
    .quo_o       (dv_quo),
    .side_o      (dv_side)
  );

  assign fin = v3a_pkg::back_t'(dv_side);

  // result selection
  v3a_pkg::word_t [2:0] r_vec;
  v3a_pkg::word_t       r_sc;
  logic                 r_tt, r_err;

  always_comb begin
    r_vec = '0;
    r_sc  = '0;
    r_tt  = 1'b0;
    r_err = 1'b0;
    unique case (fin.opcode)
      v3a_pkg::OP_ADD, v3a_pkg::OP_SUB, v3a_pkg::OP_NEG, v3a_pkg::OP_SCALE,
      v3a_pkg::OP_CROSS: begin
        r_vec = fin.vec;
      end
      v3a_pkg::OP_DOT, v3a_pkg::OP_TRIPLE, v3a_pkg::OP_NORM: begin
        r_sc = fin.rs;
      end
      v3a_pkg::OP_DIV, v3a_pkg::OP_NORMALIZE: begin
        r_err = fin.err;
        if (!fin.err) begin
          r_vec = dv_quo;
        end
      end
      v3a_pkg::OP_PROJ: begin
        r_err = fin.err;
        if (fin.err) begin
          r_vec = fin.a;
        end else begin
          r_vec[0] = dv_quo[0];
          r_vec[1] = dv_quo[1];
          r_vec[2] = ONE_Q;
        end
      end
      v3a_pkg::OP_EQ, v3a_pkg::OP_NE: begin
        r_tt = fin.tt;
      end
      default: begin
      end
    endcase
  end

  // output register
  logic [135:0] m_data_q;
  logic         m_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= {7'b0, r_tt, r_sc, r_vec[2], r_vec[1], r_vec[0]};
      m_err_q  <= r_err;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_err_q;

  // an error result carries no scalar and no test outcome
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[128:96] == '0))
    else $error("error result with scalar or test bit set");

  // a true test outcome comes with a zero vector and no error
  a_test_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[128]) |-> ((m_axis_tdata[95:0] == '0) && !m_axis_tuser[0]))
    else $error("test result with vector or error set");

  // squared threshold tracks the threshold
  a_eps_sq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eps_sq_q == (32'(eps_q) * 32'(eps_q)))
    else $error("squared threshold out of step");

endmodule

>>> dv/tb_vector3_alu.sv
// tb_vector3_alu: self-checking testbench for the vector3_alu fixed-point vector ALU
// depends on v3a_pkg and rtl/vector3_alu.sv; predicts every result in the bench itself

module tb_vector3_alu;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC       = 16;
  localparam int unsigned DRAIN_WAIT = 80;
  localparam int unsigned CYCLE_CAP  = 400000;

  typedef logic signed [31:0]  s32_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [v3a_pkg::OP_W-1:0] op;
    s32_t                     a[3];
    s32_t                     b[3];
    s32_t                     c[3];
    s32_t                     s;
  } vec_op_t;

  typedef struct {
    s32_t r[3];
    s32_t rs;
    logic tt;
    logic err;
  } vec_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [319:0] s_axis_tdata = '0;
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  vec_res_t    pending_results[$];
  logic [15:0] eps_model = v3a_pkg::EPS_RESET;
  int unsigned send_idle = 0;
  int unsigned sink_idle = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  vec_res_t    exp_r;

  vector3_alu i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // saturate to the signed word range
  function automatic s32_t clamp(input wide_t v);
    if (v > 128'sd2147483647) return 32'sh7fff_ffff;
    if (v < -128'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic wide_t mag_w(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // quotient num * 2^frac / den, truncated toward zero
  function automatic wide_t qdiv(input wide_t num, input wide_t den);
    wide_t q;
    q = (mag_w(num) << FRAC) / mag_w(den);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic wide_t vec_norm(input wide_t v[3]);
    wide_t sq;
    sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    return wide_t'(isqrt(sq[63:0]));
  endfunction

  // expected outcome of one operation under the current threshold
  function automatic vec_res_t predict_vec_op(input vec_op_t it, input logic [15:0] eps);
    vec_res_t o;
    wide_t a[3], b[3], c[3], t[3];
    wide_t s, d, e, m, sum;
    logic  eq;
    o.r = '{0, 0, 0};
    o.rs = 0;
    o.tt = 1'b0;
    o.err = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = it.a[i];
      b[i] = it.b[i];
      c[i] = it.c[i];
    end
    s = it.s;
    e = wide_t'(eps);
    case (it.op)
      v3a_pkg::OP_ADD: for (int i = 0; i < 3; i++) o.r[i] = clamp(a[i] + b[i]);
      v3a_pkg::OP_SUB: for (int i = 0; i < 3; i++) o.r[i] = clamp(a[i] - b[i]);
      v3a_pkg::OP_NEG: for (int i = 0; i < 3; i++) o.r[i] = clamp(-a[i]);
      v3a_pkg::OP_SCALE: for (int i = 0; i < 3; i++) o.r[i] = clamp((a[i] * s) >>> FRAC);
      v3a_pkg::OP_DIV: begin
        if (s == 0 || mag_w(s) < e) o.err = 1'b1;
        else for (int i = 0; i < 3; i++) o.r[i] = clamp(qdiv(a[i], s));
      end
      v3a_pkg::OP_CROSS, v3a_pkg::OP_TRIPLE: begin
        t[0] = clamp((a[1] * b[2] - a[2] * b[1]) >>> FRAC);
        t[1] = clamp((a[2] * b[0] - a[0] * b[2]) >>> FRAC);
        t[2] = clamp((a[0] * b[1] - a[1] * b[0]) >>> FRAC);
        if (it.op == v3a_pkg::OP_CROSS) begin
          for (int i = 0; i < 3; i++) o.r[i] = t[i][31:0];
        end else begin
          o.rs = clamp((t[0] * c[0] + t[1] * c[1] + t[2] * c[2]) >>> FRAC);
        end
      end
      v3a_pkg::OP_DOT: o.rs = clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC);
      v3a_pkg::OP_NORM: o.rs = clamp(vec_norm(a));
      v3a_pkg::OP_NORMALIZE: begin
        d = vec_norm(a);
        if (d == 0 || d < e) o.err = 1'b1;
        else for (int i = 0; i < 3; i++) o.r[i] = clamp(qdiv(a[i], d));
      end
      v3a_pkg::OP_PROJ: begin
        if (mag_w(a[2]) <= e) begin
          o.err = 1'b1;
          for (int i = 0; i < 3; i++) o.r[i] = it.a[i];
        end else begin
          o.r[0] = clamp(qdiv(a[0], a[2]));
          o.r[1] = clamp(qdiv(a[1], a[2]));
          o.r[2] = 32'sd1 <<< FRAC;
        end
      end
      v3a_pkg::OP_EQ, v3a_pkg::OP_NE: begin
        eq = 1'b1;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          m = mag_w(a[i] - b[i]);
          if (m > 128'sd65535) eq = 1'b0;
          else sum = sum + m * m;
        end
        if (eq) eq = (sum < e * e);
        o.tt = (it.op == v3a_pkg::OP_EQ) ? eq : ~eq;
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch %s: expected %h got %h at cycle %0d", what, want, got, n_cycles);
    n_errors++;
  endtask

  // result side: random back-pressure and comparison of each transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'h0, m_axis_tdata[31:0]);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== exp_r.r[0])
          report_mismatch("r_x", exp_r.r[0], m_axis_tdata[31:0]);
        if (m_axis_tdata[63:32] !== exp_r.r[1])
          report_mismatch("r_y", exp_r.r[1], m_axis_tdata[63:32]);
        if (m_axis_tdata[95:64] !== exp_r.r[2])
          report_mismatch("r_z", exp_r.r[2], m_axis_tdata[95:64]);
        if (m_axis_tdata[127:96] !== exp_r.rs)
          report_mismatch("r_scalar", exp_r.rs, m_axis_tdata[127:96]);
        if (m_axis_tdata[128] !== exp_r.tt)
          report_mismatch("test_true", 32'(exp_r.tt), 32'(m_axis_tdata[128]));
        if (m_axis_tuser[0] !== exp_r.err)
          report_mismatch("error", 32'(exp_r.err), 32'(m_axis_tuser[0]));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
  end

  // one operation transfer, with a random gap ahead of it
  task automatic send_vec_op(input vec_op_t it);
    if ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {it.s, it.c[2], it.c[1], it.c[0], it.b[2], it.b[1], it.b[0],
                      it.a[2], it.a[1], it.a[0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_vec_op(it, eps_model));
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [15:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    eps_model = v;
  endtask

  function automatic vec_op_t make_op(input logic [v3a_pkg::OP_W-1:0] op,
                                      input s32_t ax, input s32_t ay, input s32_t az,
                                      input s32_t bx, input s32_t by, input s32_t bz,
                                      input s32_t s);
    vec_op_t it;
    it.op = op;
    it.a = '{ax, ay, az};
    it.b = '{bx, by, bz};
    it.c = '{bx ^ 32'h5a5a_0000, az, 32'sh8000_0000};
    it.s = s;
    return it;
  endfunction

  // field value: extremes, small, mid-range or fully random
  function automatic s32_t pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2, 3: return s32_t'($urandom_range(0, 40)) * (($urandom_range(0, 1) != 0) ? 1 : -1);
      4: return s32_t'($urandom_range(0, 70000)) - 35000;
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_op_t random_op();
    vec_op_t it;
    s32_t    near;
    s32_t    sgn;
    it.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                         : 4'($urandom_range(0, 12));
    for (int i = 0; i < 3; i++) begin
      it.a[i] = pick_word();
      it.b[i] = pick_word();
      it.c[i] = pick_word();
    end
    it.s = pick_word();
    near = s32_t'($urandom_range(0, 3)) - 2;
    sgn  = ($urandom_range(0, 1) != 0) ? 1 : -1;
    // steer the operand of a special case onto or around the threshold
    if ($urandom_range(0, 2) == 0) begin
      case (it.op)
        v3a_pkg::OP_DIV: it.s = (s32_t'(eps_model) + near) * sgn;
        v3a_pkg::OP_PROJ: it.a[2] = (s32_t'(eps_model) + near) * sgn;
        v3a_pkg::OP_NORMALIZE:
          it.a = '{s32_t'(eps_model) + near, 0, s32_t'($urandom_range(0, 1))};
        v3a_pkg::OP_EQ, v3a_pkg::OP_NE: for (int i = 0; i < 3; i++)
          it.b[i] = it.a[i] + s32_t'($urandom_range(0, 2 * eps_model)) - s32_t'(eps_model);
        default: ;
      endcase
    end
    return it;
  endfunction

  // every opcode at the extremes and each special case once
  task automatic test_directed();
    s32_t mx, mn, one;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    one = 32'sh0001_0000;
    send_vec_op(make_op(v3a_pkg::OP_ADD, mx, mn, mx, mx, mn, -1, 0));
    send_vec_op(make_op(v3a_pkg::OP_SUB, mn, mx, 0, mx, mn, mn, 0));
    send_vec_op(make_op(v3a_pkg::OP_NEG, mn, mx, 0, 0, 0, 0, 0));
    send_vec_op(make_op(v3a_pkg::OP_SCALE, mx, mn, -3, 0, 0, 0, mn));
    send_vec_op(make_op(v3a_pkg::OP_SCALE, one, -one, 5, 0, 0, 0, -one));
    send_vec_op(make_op(v3a_pkg::OP_DIV, mx, mn, one, 0, 0, 0, 0));
    send_vec_op(make_op(v3a_pkg::OP_DIV, mx, mn, one, 0, 0, 0, 1));
    send_vec_op(make_op(v3a_pkg::OP_DIV, mx, mn, -7, 0, 0, 0, -one));
    send_vec_op(make_op(v3a_pkg::OP_CROSS, mn, mn, mx, mx, mn, mn, 0));
    send_vec_op(make_op(v3a_pkg::OP_DOT, mn, mn, mn, mn, mn, mn, 0));
    send_vec_op(make_op(v3a_pkg::OP_TRIPLE, mx, mn, one, mn, mx, -one, 0));
    send_vec_op(make_op(v3a_pkg::OP_NORM, mn, mn, mn, 0, 0, 0, 0));
    send_vec_op(make_op(v3a_pkg::OP_NORMALIZE, 0, 0, 0, 0, 0, 0, 0));
    send_vec_op(make_op(v3a_pkg::OP_NORMALIZE, 3 * one, -4 * one, 0, 0, 0, 0, 0));
    send_vec_op(make_op(v3a_pkg::OP_PROJ, mx, mn, 1, 0, 0, 0, 0));
    send_vec_op(make_op(v3a_pkg::OP_PROJ, mx, mn, 2, 0, 0, 0, 0));
    send_vec_op(make_op(v3a_pkg::OP_PROJ, one, -one, -2 * one, 0, 0, 0, 0));
    send_vec_op(make_op(v3a_pkg::OP_EQ, 5, 6, 7, 5, 6, 7, 0));
    send_vec_op(make_op(v3a_pkg::OP_EQ, mx, 0, 0, mn, 0, 0, 0));
    send_vec_op(make_op(v3a_pkg::OP_NE, 5, 6, 7, 5, 6, 8, 0));
    send_vec_op(make_op(v3a_pkg::OP_NE, 1, 1, 1, 1, 1, 1, 0));
    send_vec_op(make_op(v3a_pkg::OP_NE + 4'd1, mx, mn, 1, 1, 1, 1, 1));
    send_vec_op(make_op(4'd15, mn, mx, 1, 1, 1, 1, 1));
  endtask

  task automatic test_random(input int unsigned n_items, input bit hold_midway);
    for (int unsigned k = 0; k < n_items; k++) begin
      if (hold_midway && k == n_items / 2) drain_results();
      send_vec_op(random_op());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_threshold(16'd0);
    test_directed();
    write_threshold(16'hffff);
    test_directed();

    send_idle = 32;
    sink_idle = 86;
    write_threshold(16'd0);
    test_random(220, 1'b0);

    send_idle = 86;
    sink_idle = 32;
    write_threshold(16'hffff);
    test_random(220, 1'b1);

    send_idle = 0;
    sink_idle = 0;
    write_threshold(16'($urandom_range(2, 65534)));
    test_random(220, 1'b1);

    drain_results();
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
